@@ hw/rtl/rvb_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvb_pkg
// Shared types and constants of the stereo comb/allpass reverb.
// ----------------------------------------------------------------------------
package rvb_pkg;

    localparam int NCOMB = 8;
    localparam int NAP   = 4;

    localparam int COMB_TUNE [NCOMB] = '{1116, 1188, 1277, 1356, 1422, 1491, 1557, 1617};
    localparam int AP_TUNE   [NAP]   = '{556, 441, 341, 225};

    localparam logic [1:0] REG_FEEDBACK = 2'd0;
    localparam logic [1:0] REG_DAMPING  = 2'd1;
    localparam logic [1:0] REG_WET_MIX  = 2'd2;

    localparam logic [15:0] FEEDBACK_RST = 16'd40960;
    localparam logic [15:0] DAMPING_RST  = 16'd22938;
    localparam logic [15:0] WET_MIX_RST  = 16'd16384;

    typedef struct packed {
        logic [15:0] feedback;
        logic [15:0] damping;
        logic [15:0] wet_mix;
    } t_cfg;

    typedef struct packed {
        logic idle;
        logic done;
    } t_lane_stat;

endpackage
`default_nettype wire

@@ hw/rtl/stereo_comb_allpass_reverb.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stereo_comb_allpass_reverb
// Stereo damped-comb / allpass reverb with wet/dry mix and APB registers.
// ----------------------------------------------------------------------------
// Left and right channels run in two lanes side by side. Each lane walks
// its 8 combs (read, damping and feedback steps, then write; one RAM read
// and write per comb) and then its 4 allpasses (read, then update and write),
// sequenced around the lane's delay-line RAM port; a new
// frame is taken once both lanes are idle, while the previous result may
// still wait at the output. After reset the lanes zero their delay lines,
// 8*COMB_BANK_DEPTH entries (16384 by default), and take no frame meanwhile.
// ----------------------------------------------------------------------------
module stereo_comb_allpass_reverb #(
    parameter int STEREO_SPREAD      = 23,
    parameter int COMB_BANK_DEPTH    = 2048,
    parameter int ALLPASS_BANK_DEPTH = 1024,
    parameter int SAMPLE_BITS        = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // left_in[15:0], right_in[31:16]
    input  wire logic [0:0]  i_s_axis_tuser,   // right_present[0]
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata,   // left_out[15:0], right_out[31:16]
    input  wire logic        i_psel,
    input  wire logic        i_penable,
    input  wire logic        i_pwrite,
    input  wire logic [3:0]  i_paddr,
    input  wire logic [31:0] i_pwdata,
    output logic [31:0]      o_prdata,
    output logic             o_pready
);
    import rvb_pkg::*;

    typedef enum logic [3:0] {
        T_IDLE = 4'b0001,
        T_RUN  = 4'b0010,
        T_MIX  = 4'b0100,
        T_OUT  = 4'b1000
    } t_top_state;

    t_top_state  r_st;
    t_cfg        r_cfg;
    logic        r_ovalid;
    logic [31:0] r_odata;

    t_lane_stat                  stat_l, stat_r;
    logic signed [SAMPLE_BITS-1:0] dry_l, wet_l, dry_r, wet_r;
    logic signed [15:0]          mix_l, mix_r, x_r;
    logic                        in_acc, mix_done, wr, out_ld;

    assign o_pready = 1'b1;
    assign wr       = i_psel && i_penable && i_pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.feedback <= FEEDBACK_RST;
            r_cfg.damping  <= DAMPING_RST;
            r_cfg.wet_mix  <= WET_MIX_RST;
        end else if (wr) begin
            case (i_paddr[3:2])
                REG_FEEDBACK: r_cfg.feedback <= i_pwdata[15:0];
                REG_DAMPING:  r_cfg.damping  <= i_pwdata[15:0];
                REG_WET_MIX:  r_cfg.wet_mix  <= i_pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (i_paddr[3:2])
            REG_FEEDBACK: o_prdata = {16'd0, r_cfg.feedback};
            REG_DAMPING:  o_prdata = {16'd0, r_cfg.damping};
            REG_WET_MIX:  o_prdata = {16'd0, r_cfg.wet_mix};
            default:      o_prdata = '0;
        endcase
    end

    assign o_s_axis_tready = (r_st == T_IDLE) && stat_l.idle && stat_r.idle;
    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign x_r = i_s_axis_tuser[0] ? $signed(i_s_axis_tdata[31:16])
                                   : $signed(i_s_axis_tdata[15:0]);

    rvb_lane #(
        .SPREAD(0), .COMB_DEPTH(COMB_BANK_DEPTH),
        .AP_DEPTH(ALLPASS_BANK_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane_l (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_start(in_acc),
        .i_x($signed(i_s_axis_tdata[15:0])), .o_stat(stat_l),
        .o_dry(dry_l), .o_wet(wet_l)
    );

    rvb_lane #(
        .SPREAD(STEREO_SPREAD), .COMB_DEPTH(COMB_BANK_DEPTH),
        .AP_DEPTH(ALLPASS_BANK_DEPTH), .SAMPLE_BITS(SAMPLE_BITS)
    ) u_lane_r (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg(r_cfg), .i_start(in_acc),
        .i_x(x_r), .o_stat(stat_r), .o_dry(dry_r), .o_wet(wet_r)
    );

    rvb_mix #(.SAMPLE_BITS(SAMPLE_BITS)) u_mix (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_start((r_st == T_RUN) && stat_l.done),
        .i_wet_mix(r_cfg.wet_mix),
        .i_dry_l(dry_l), .i_wet_l(wet_l), .i_dry_r(dry_r), .i_wet_r(wet_r),
        .o_done(mix_done), .o_left(mix_l), .o_right(mix_r)
    );

    // output word waits in its register; load once it is free
    assign out_ld = (r_st == T_OUT) && (!r_ovalid || i_m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= T_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= out_ld || (r_ovalid && !i_m_axis_tready);
            case (r_st)
                T_IDLE: if (in_acc) r_st <= T_RUN;
                T_RUN:  if (stat_l.done) r_st <= T_MIX;
                T_MIX:  if (mix_done) r_st <= T_OUT;
                T_OUT: begin
                    if (out_ld) begin
                        r_odata  <= {mix_r, mix_l};
                        r_st     <= T_IDLE;
                    end
                end
                default: r_st <= T_IDLE;
            endcase
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;
endmodule
`default_nettype wire

@@ hw/rtl/rvb_ram.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvb_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module rvb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule
`default_nettype wire

@@ hw/rtl/rvb_lane.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvb_lane
// One channel: 8 damped combs, averaged, then 4 series allpasses.
// Clears its delay lines after reset, one entry a cycle.
// ----------------------------------------------------------------------------
module rvb_lane #(
    parameter int SPREAD      = 0,
    parameter int COMB_DEPTH  = 2048,
    parameter int AP_DEPTH    = 1024,
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rvb_pkg::t_cfg                 i_cfg,
    input  wire logic                          i_start,
    input  wire logic signed [15:0]            i_x,
    output rvb_pkg::t_lane_stat                o_stat,
    output logic signed [SAMPLE_BITS-1:0]      o_dry,
    output logic signed [SAMPLE_BITS-1:0]      o_wet
);
    import rvb_pkg::*;

    localparam int SB    = SAMPLE_BITS;
    localparam int PW    = SB + 19;
    localparam int CW    = $clog2(COMB_DEPTH);
    localparam int AW    = $clog2(AP_DEPTH);
    localparam int CTOT  = NCOMB * COMB_DEPTH;
    localparam int ATOT  = NAP * AP_DEPTH;
    localparam int CAW   = $clog2(CTOT);
    localparam int AAW   = $clog2(ATOT);
    localparam logic signed [PW-1:0] SMAX = PW'((64'sd1 <<< (SB - 1)) - 64'sd1);
    localparam logic signed [PW-1:0] SMIN = -SMAX - PW'(1);
    localparam logic signed [PW-1:0] RND  = PW'(32768);

    typedef enum logic [10:0] {
        S_CLR  = 11'b00000000001,
        S_IDLE = 11'b00000000010,
        S_CRD  = 11'b00000000100,
        S_CM1  = 11'b00000001000,
        S_CM2  = 11'b00000010000,
        S_CM3  = 11'b00000100000,
        S_CWR  = 11'b00001000000,
        S_AVG  = 11'b00010000000,
        S_ARD  = 11'b00100000000,
        S_AM   = 11'b01000000000,
        S_DONE = 11'b10000000000
    } t_state;

    function automatic logic signed [SB-1:0] sat_s(input logic signed [PW-1:0] v);
        logic signed [PW-1:0] t;
        t = v;
        if (v > SMAX) t = SMAX;
        if (v < SMIN) t = SMIN;
        return t[SB-1:0];
    endfunction

    function automatic logic [CW-1:0] comb_len(input logic [2:0] i);
        int t;
        t = COMB_TUNE[i] + SPREAD;
        if (t < 1) t = 1;
        if (t > COMB_DEPTH - 1) t = COMB_DEPTH - 1;
        return t[CW-1:0];
    endfunction

    function automatic logic [AW-1:0] ap_len(input logic [1:0] i);
        int t;
        t = AP_TUNE[i] + SPREAD;
        if (t < 1) t = 1;
        if (t > AP_DEPTH - 1) t = AP_DEPTH - 1;
        return t[AW-1:0];
    endfunction

    t_state                 r_st;
    logic [CAW-1:0]         r_ccnt;
    logic [2:0]             r_idx;
    logic [1:0]             r_aidx;
    logic [CW-1:0]          r_cpos [NCOMB];
    logic [AW-1:0]          r_apos [NAP];
    logic signed [SB-1:0]   r_fs   [NCOMB];
    logic signed [SB-1:0]   r_x;
    logic signed [SB+2:0]   r_sum;
    logic signed [PW-1:0]   r_p1;
    logic signed [PW-1:0]   r_q;
    logic signed [SB-1:0]   r_y;
    logic                   r_done;

    logic [CW-1:0]          clen, cpos, cpos_n;
    logic [AW-1:0]          alen, apos, apos_n;
    logic [CAW-1:0]         caddr;
    logic [AAW-1:0]         aaddr;
    logic [SB-1:0]          c_rdata, a_rdata;
    logic signed [SB-1:0]   o_s, b_s, c_wv, a_wv, f_new, y_new;
    logic signed [PW-1:0]   acc, hb;
    logic                   clr, c_we, a_we;

    // stray positions restart at zero
    assign clen   = comb_len(r_idx);
    assign cpos   = (r_cpos[r_idx] >= clen) ? '0 : r_cpos[r_idx];
    assign cpos_n = ((cpos + CW'(1)) == clen) ? '0 : cpos + CW'(1);
    assign alen   = ap_len(r_aidx);
    assign apos   = (r_apos[r_aidx] >= alen) ? '0 : r_apos[r_aidx];
    assign apos_n = ((apos + AW'(1)) == alen) ? '0 : apos + AW'(1);
    assign caddr  = CAW'(r_idx * COMB_DEPTH) + CAW'(cpos);
    assign aaddr  = AAW'(r_aidx * AP_DEPTH) + AAW'(apos);

    assign o_s   = $signed(c_rdata);
    assign b_s   = $signed(a_rdata);
    assign acc   = r_p1 + PW'(r_fs[r_idx]) * PW'($signed({1'b0, i_cfg.damping}));
    assign f_new = sat_s((acc + RND) >>> 16);
    assign c_wv  = sat_s(PW'(r_x) + ((r_q + RND) >>> 16));
    // b*0.5 rounded is (b+1)>>1
    assign hb    = (PW'(b_s) + PW'(1)) >>> 1;
    assign a_wv  = sat_s(PW'(r_y) + hb);
    assign y_new = sat_s(PW'(b_s) - PW'(r_y));

    assign clr  = (r_st == S_CLR);
    assign c_we = clr || (r_st == S_CWR);
    assign a_we = (clr && ({{(32 - CAW){1'b0}}, r_ccnt} < 32'(ATOT))) || (r_st == S_AM);

    rvb_ram #(.WIDTH(SB), .DEPTH(CTOT)) u_comb_ram (
        .i_clk   (i_clk),
        .i_we    (c_we),
        .i_waddr (clr ? r_ccnt : caddr),
        .i_wdata (clr ? '0 : c_wv),
        .i_re    (r_st == S_CRD),
        .i_raddr (caddr),
        .o_rdata (c_rdata)
    );

    rvb_ram #(.WIDTH(SB), .DEPTH(ATOT)) u_ap_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (clr ? r_ccnt[AAW-1:0] : aaddr),
        .i_wdata (clr ? '0 : a_wv),
        .i_re    (r_st == S_ARD),
        .i_raddr (aaddr),
        .o_rdata (a_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st   <= S_CLR;
            r_ccnt <= '0;
            r_idx  <= '0;
            r_aidx <= '0;
            r_done <= 1'b0;
            for (int i = 0; i < NCOMB; i++) begin
                r_cpos[i] <= '0;
                r_fs[i]   <= '0;
            end
            for (int i = 0; i < NAP; i++) begin
                r_apos[i] <= '0;
            end
        end else begin
            r_done <= (r_st == S_DONE);
            case (r_st)
                S_CLR: begin
                    r_ccnt <= r_ccnt + CAW'(1);
                    if (r_ccnt == CAW'(CTOT - 1)) r_st <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_x   <= sat_s(PW'(i_x));
                        r_sum <= '0;
                        r_idx <= '0;
                        r_st  <= S_CRD;
                    end
                end
                S_CRD: r_st <= S_CM1;
                S_CM1: begin
                    r_p1  <= PW'(o_s) * PW'($signed({1'b0, 17'(65536) - 17'(i_cfg.damping)}));
                    r_sum <= r_sum + (SB + 3)'(o_s);
                    r_st  <= S_CM2;
                end
                S_CM2: begin
                    r_fs[r_idx] <= f_new;
                    r_st        <= S_CM3;
                end
                S_CM3: begin
                    r_q  <= PW'(r_fs[r_idx]) * PW'($signed({1'b0, i_cfg.feedback}));
                    r_st <= S_CWR;
                end
                S_CWR: begin
                    r_cpos[r_idx] <= cpos_n;
                    r_idx         <= r_idx + 3'd1;
                    r_st          <= (r_idx == 3'(NCOMB - 1)) ? S_AVG : S_CRD;
                end
                S_AVG: begin
                    r_y    <= sat_s((PW'(r_sum) + PW'(4)) >>> 3);
                    r_aidx <= '0;
                    r_st   <= S_ARD;
                end
                S_ARD: r_st <= S_AM;
                S_AM: begin
                    r_y            <= y_new;
                    r_apos[r_aidx] <= apos_n;
                    r_aidx         <= r_aidx + 2'd1;
                    r_st           <= (r_aidx == 2'(NAP - 1)) ? S_DONE : S_ARD;
                end
                S_DONE: begin
                    r_st   <= S_IDLE;
                end
                default: r_st <= S_CLR;
            endcase
        end
    end

    assign o_stat.idle = (r_st == S_IDLE);
    assign o_stat.done = r_done;
    assign o_dry       = r_x;
    assign o_wet       = r_y;
endmodule
`default_nettype wire

@@ hw/rtl/rvb_mix.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvb_mix
// Merging stage: wet/dry crossfade of both lanes, saturated to 16 bits.
// ----------------------------------------------------------------------------
module rvb_mix #(
    parameter int SAMPLE_BITS = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [15:0]                   i_wet_mix,
    input  wire logic signed [SAMPLE_BITS-1:0] i_dry_l,
    input  wire logic signed [SAMPLE_BITS-1:0] i_wet_l,
    input  wire logic signed [SAMPLE_BITS-1:0] i_dry_r,
    input  wire logic signed [SAMPLE_BITS-1:0] i_wet_r,
    output logic                               o_done,
    output logic signed [15:0]                 o_left,
    output logic signed [15:0]                 o_right
);
    localparam int MW = SAMPLE_BITS + 19;

    function automatic logic signed [15:0] sat16(input logic signed [MW-1:0] v);
        logic signed [MW-1:0] t;
        t = v;
        if (v > MW'(32767)) t = MW'(32767);
        if (v < -MW'(32768)) t = -MW'(32768);
        return t[15:0];
    endfunction

    logic signed [MW-1:0] r_pd [2];
    logic signed [MW-1:0] r_pw [2];
    logic                 r_v1, r_v2;
    logic signed [MW-1:0] dcoef, wcoef, rs_l, rs_r;

    assign dcoef = MW'($signed({1'b0, 17'(65536) - 17'(i_wet_mix)}));
    assign wcoef = MW'($signed({1'b0, i_wet_mix}));
    assign rs_l  = (r_pd[0] + r_pw[0] + MW'(32768)) >>> 16;
    assign rs_r  = (r_pd[1] + r_pw[1] + MW'(32768)) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
        end
        if (i_start) begin
            r_pd[0] <= MW'(i_dry_l) * dcoef;
            r_pw[0] <= MW'(i_wet_l) * wcoef;
            r_pd[1] <= MW'(i_dry_r) * dcoef;
            r_pw[1] <= MW'(i_wet_r) * wcoef;
        end
        if (r_v1) begin
            o_left  <= sat16(rs_l);
            o_right <= sat16(rs_r);
        end
    end

    assign o_done = r_v2;
endmodule
`default_nettype wire
